>>> sv/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
`default_nettype none

package bba_pkg;

  localparam logic [1:0] MODE_FIND = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_TEST = 2'd2;

  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_RANGE   = 2'd1;
  localparam logic [1:0] OUT_NOMATCH = 2'd2;
  localparam logic [1:0] OUT_USED    = 2'd3;

  localparam logic       REG_BITS_IN_USE = 1'b0;
  localparam logic [12:0] BITS_RESET     = 13'd4096;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] position;
    logic        bit_value;
  } bba_req_t;

  typedef struct packed {
    logic [11:0] found_position;
    logic [1:0]  outcome;
    logic [7:0]  byte_after;
  } bba_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WAIT,
    ST_EVAL,
    ST_POST
  } bba_state_t;

endpackage

`default_nettype wire

>>> sv/block_bitmap_allocator.sv
// Block allocation bitmap with find-first, set and test requests.
// Sequence: a rejected request goes straight to the post state; set and test pass through wait,
//   evaluate and post; a find repeats wait and evaluate per byte scanned (one memory read each).
// Throughput: one request at a time; the next beat is taken once the result is registered.
// Reset: the store is cleared by a pass over MAX_BITS/8 bytes (rounded up), one byte per cycle;
//   requests stall during the pass, configuration writes are taken throughout.
`default_nettype none

module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BITS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire bba_req_t    req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output bba_rsp_t         rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH * 8 + 9);
  localparam int LW    = (PW > 13) ? PW : 13;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [7:0]    mem_wd;

  bba_state_t    state, state_next;
  logic [AW-1:0] addr, addr_next;
  bba_req_t      cur, cur_next;
  bba_rsp_t      res, res_next;
  logic          rsp_load;
  logic [12:0]   bits_in_use;

  logic [LW-1:0] eff;
  logic [LW-1:0] bits_ext;
  logic [LW-1:0] base;
  logic [LW-1:0] cur_pos;
  logic [LW-1:0] req_pos;
  logic [LW-1:0] hit_pos;
  logic          hit;
  logic [7:0]    set_mask;
  logic [7:0]    set_byte;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BITS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BITS_IN_USE) begin
      bits_in_use <= pwdata[12:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_BITS_IN_USE) begin
      prdata = {19'd0, bits_in_use};
    end
  end

  assign bits_ext = LW'(bits_in_use);
  assign eff      = (bits_ext > LW'(MAX_BITS)) ? LW'(MAX_BITS) : bits_ext;
  assign base     = LW'({addr, 3'b000});
  assign cur_pos  = LW'(cur.position);
  assign req_pos  = LW'(req.position);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wd;
    end
    rd_data <= mem[addr];
  end

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = 7; j >= 0; j--) begin
      if ((base + LW'(j)) >= cur_pos && (base + LW'(j)) < eff &&
          rd_data[j] == cur.bit_value) begin
        hit     = 1'b1;
        hit_pos = base + LW'(j);
      end
    end
  end

  assign set_mask = 8'h01 << cur.position[2:0];
  assign set_byte = cur.bit_value ? (rd_data | set_mask) : (rd_data & ~set_mask);

  always_comb begin
    state_next = state;
    addr_next  = addr;
    cur_next   = cur;
    res_next   = res;
    req_stall  = 1'b1;
    mem_we     = 1'b0;
    mem_wd     = 8'd0;
    rsp_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        addr_next = addr + AW'(1);
        if (addr == AW'(DEPTH - 1)) begin
          addr_next  = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cur_next  = req;
          addr_next = AW'(req.position >> 3);
          res_next  = '0;
          if (req_pos >= eff || (req.mode != MODE_FIND && req.mode != MODE_SET &&
                                 req.mode != MODE_TEST)) begin
            res_next.outcome = OUT_RANGE;
            state_next       = ST_POST;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_POST;
        case (cur.mode)
          MODE_FIND: begin
            if (hit) begin
              res_next.found_position = hit_pos[11:0];
              res_next.outcome        = OUT_OK;
            end else if (base + LW'(8) >= eff) begin
              res_next.outcome = OUT_NOMATCH;
            end else begin
              addr_next  = addr + AW'(1);
              state_next = ST_WAIT;
            end
          end
          MODE_SET: begin
            mem_we              = 1'b1;
            mem_wd              = set_byte;
            res_next.byte_after = set_byte;
            res_next.outcome    = OUT_OK;
          end
          default: begin
            res_next.outcome = rd_data[cur.position[2:0]] ? OUT_USED : OUT_OK;
          end
        endcase
      end
      ST_POST: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

>>> sv/bba_checker.sv
// Port-level checks for the block bitmap allocator, bound to the top level.
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_stall,
  input wire logic     rsp_valid,
  input wire logic     rsp_stall,
  input wire bba_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  a_clear_stall: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during the clearing pass");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.outcome == OUT_RANGE || rsp.outcome == OUT_NOMATCH) |->
      rsp.found_position == 12'd0 && rsp.byte_after == 8'd0)
    else $error("rejected or unmatched result carries data");

  a_byte_only_set: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.byte_after != 8'd0 |->
      rsp.outcome == OUT_OK && rsp.found_position == 12'd0)
    else $error("byte reported outside a successful set");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
